// ===== hdl/ssd_pkg.sv =====
// Shared types and constants for the servo status packet deframer.
// Depends on nothing; the parser, result register, top level, checker and testbench refer to it by scoped names.
package ssd_pkg;

  localparam logic [7:0] START_BYTE     = 8'hFF;
  localparam int unsigned FRAME_OVERHEAD = 4;  // two start bytes, id and length
  localparam int unsigned MAX_BYTES_W    = 9;
  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 9'd259;

  typedef enum logic [2:0] {
    PH_START1 = 3'd0,
    PH_START2 = 3'd1,
    PH_ID     = 3'd2,
    PH_LEN    = 3'd3,
    PH_BODY   = 3'd4,
    PH_CSUM   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_CSUM  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic [7:0] body_index;
    logic [7:0] device_id;
    logic [7:0] frame_length;
    logic       last;
    status_e    status;
  } result_t;

endpackage

// ===== hdl/ssd_byte_if.sv =====
// Valid/ready channel interfaces of the deframer: received bytes in, results out.
// Depends on nothing.
interface ssd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic [7:0] body_index;
  logic [7:0] device_id;
  logic [7:0] frame_length;
  logic       last;
  logic [1:0] status;

  modport source (
    output valid, output body_byte, output body_index, output device_id,
    output frame_length, output last, output status, input ready
  );
  modport sink (
    input valid, input body_byte, input body_index, input device_id,
    input frame_length, input last, input status, output ready
  );
endinterface

// ===== hdl/ssd_in_stage.sv =====
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on nothing outside this file.
module ssd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  assign ready_o = !valid_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== hdl/ssd_parser.sv =====
// Frame parser of the deframer: phase machine, running checksum and counters.
// Depends on ssd_pkg for the phase and status codes and the result struct.
module ssd_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ssd_pkg::MAX_BYTES_W-1:0]    cfg_wdata_i,
  input  logic                               step_i,
  input  logic [7:0]                         byte_i,
  output logic                               res_valid_o,
  output ssd_pkg::result_t                   res_o
);

  ssd_pkg::phase_e phase_q, phase_d;
  logic [ssd_pkg::MAX_BYTES_W-1:0] max_q;
  logic [7:0] id_q, id_d;
  logic [7:0] len_q, len_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_q, count_d;
  logic       start_ok;
  logic       len_bad;
  logic [ssd_pkg::MAX_BYTES_W-1:0] frame_bytes;

  assign start_ok    = (byte_i == ssd_pkg::START_BYTE);
  assign frame_bytes = {1'b0, byte_i} + ssd_pkg::MAX_BYTES_W'(ssd_pkg::FRAME_OVERHEAD);
  assign len_bad     = (byte_i == 8'd0) || (frame_bytes > max_q);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        ssd_pkg::PH_START2: phase_d = start_ok ? ssd_pkg::PH_ID : ssd_pkg::PH_START1;
        ssd_pkg::PH_ID:     phase_d = ssd_pkg::PH_LEN;
        ssd_pkg::PH_LEN: begin
          if (len_bad) begin
            phase_d = ssd_pkg::PH_START1;
          end else if (byte_i == 8'd1) begin
            phase_d = ssd_pkg::PH_CSUM;
          end else begin
            phase_d = ssd_pkg::PH_BODY;
          end
        end
        ssd_pkg::PH_BODY:   phase_d = (left_q == 8'd1) ? ssd_pkg::PH_CSUM : ssd_pkg::PH_BODY;
        ssd_pkg::PH_CSUM:   phase_d = ssd_pkg::PH_START1;
        default:            phase_d = start_ok ? ssd_pkg::PH_START2 : ssd_pkg::PH_START1;
      endcase
    end
  end

  // Results and frame bookkeeping.
  always_comb begin
    id_d        = id_q;
    len_d       = len_q;
    left_d      = left_q;
    sum_d       = sum_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      case (phase_q)
        ssd_pkg::PH_START2: begin
          if (!start_ok) begin
            res_valid_o = 1'b1;
            res_o.last  = 1'b1;
            res_o.status = ssd_pkg::ST_BAD_START;
          end
        end
        ssd_pkg::PH_ID: begin
          id_d = byte_i;
        end
        ssd_pkg::PH_LEN: begin
          len_d = byte_i;
          if (len_bad) begin
            res_valid_o        = 1'b1;
            res_o.device_id    = id_q;
            res_o.frame_length = byte_i;
            res_o.last         = 1'b1;
            res_o.status       = ssd_pkg::ST_BAD_LEN;
          end else begin
            sum_d   = id_q + byte_i;
            count_d = 8'd0;
            left_d  = byte_i - 8'd1;
          end
        end
        ssd_pkg::PH_BODY: begin
          res_valid_o        = 1'b1;
          res_o.body_byte    = byte_i;
          res_o.body_index   = count_q;
          res_o.device_id    = id_q;
          res_o.frame_length = len_q;
          res_o.status       = ssd_pkg::ST_OK;
          sum_d   = sum_q + byte_i;
          count_d = count_q + 8'd1;
          left_d  = left_q - 8'd1;
        end
        ssd_pkg::PH_CSUM: begin
          res_valid_o        = 1'b1;
          res_o.device_id    = id_q;
          res_o.frame_length = len_q;
          res_o.last         = 1'b1;
          res_o.status       = (byte_i == ~sum_q) ? ssd_pkg::ST_OK : ssd_pkg::ST_BAD_CSUM;
        end
        default: begin
          if (!start_ok) begin
            res_valid_o  = 1'b1;
            res_o.last   = 1'b1;
            res_o.status = ssd_pkg::ST_BAD_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ssd_pkg::PH_START1;
      max_q   <= ssd_pkg::MAX_BYTES_RESET;
      id_q    <= 8'd0;
      len_q   <= 8'd0;
      left_q  <= 8'd0;
      sum_q   <= 8'd0;
      count_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== hdl/ssd_out_stage.sv =====
// Result register of the deframer: holds one result until the receiver takes it.
// Depends on ssd_pkg for the result struct.
module ssd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ssd_pkg::result_t res_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output ssd_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  ssd_pkg::result_t res_q, res_d;

  // The register frees up in the same cycle in which its result is taken.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== hdl/servo_status_packet_deframer.sv =====
// Status frame deframer for a half-duplex servo bus.
// Usage: received bytes enter on rx_i, one per request; results leave on res_o.
// A frame is two 0xFF start bytes, an id, a length L, L-1 body bytes and a
// checksum. Each body byte yields one result with its index; the end of the
// frame, or any error, yields a result with last set and a status code
// (ok, bad start bytes, bad length, checksum failure). Bytes that only
// advance the parser (start bytes, id, length) yield no result.
// cfg_we_i/cfg_wdata_i write the largest accepted frame size; write it only
// while no byte is in flight.
// A byte that is accepted is held in the input register, then parsed into the result
// register, from which its result is offered; the parse itself is combinational.
// Throughput: one byte per cycle while the receiver does not stall, set by the single
// parse step between the input register and the result register.
// When the receiver stalls, the result register holds its result, the parser
// waits and the input register fills; rx_i.ready then drops.
// Reset clears the phase to waiting for a start byte, all counters and sums,
// and sets the frame size limit to 259.
// Depends on ssd_pkg, the channel interfaces, ssd_in_stage, ssd_parser and
// ssd_out_stage.
module servo_status_packet_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ssd_byte_if.sink                        rx_i,
  ssd_result_if.source                    res_o,
  input  logic                            cfg_we_i,
  input  logic [ssd_pkg::MAX_BYTES_W-1:0] cfg_wdata_i
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             out_space;
  logic             res_valid;
  ssd_pkg::result_t res;
  ssd_pkg::result_t out_res;

  assign advance = in_valid && out_space;

  ssd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .byte_i    (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  ssd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ssd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .space_o (out_space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (out_res)
  );

  assign res_o.body_byte    = out_res.body_byte;
  assign res_o.body_index   = out_res.body_index;
  assign res_o.device_id    = out_res.device_id;
  assign res_o.frame_length = out_res.frame_length;
  assign res_o.last         = out_res.last;
  assign res_o.status       = out_res.status;

endmodule

// ===== hdl/ssd_checker.sv =====
// Port-level checks for the servo status packet deframer, bound to its top level.
// Depends on ssd_pkg for the status codes.
module ssd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] body_byte_i,
  input logic [7:0] body_index_i,
  input logic [7:0] device_id_i,
  input logic [7:0] frame_length_i,
  input logic       last_i,
  input logic [1:0] status_i
);

  // A stalled result stays valid and keeps its body byte, index, last and status until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(body_byte_i)
      && $stable(body_index_i) && $stable(last_i) && $stable(status_i))
    else $error("stalled result changed");

  // Body results always carry the ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_i |-> status_i == ssd_pkg::ST_OK)
    else $error("body result with error status");

  // A final result carries no body byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && last_i |-> body_byte_i == 8'd0 && body_index_i == 8'd0)
    else $error("final result with body data");

  // A bad start happens before an id or length is known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ssd_pkg::ST_BAD_START
      |-> last_i && device_id_i == 8'd0 && frame_length_i == 8'd0)
    else $error("bad start result carries frame data");

  // A body index stays inside the body that the length byte announced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_i |-> ({1'b0, body_index_i} + 9'd1) < {1'b0, frame_length_i})
    else $error("body index beyond frame length");

endmodule

bind servo_status_packet_deframer ssd_checker u_ssd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .body_byte_i    (res_o.body_byte),
  .body_index_i   (res_o.body_index),
  .device_id_i    (res_o.device_id),
  .frame_length_i (res_o.frame_length),
  .last_i         (res_o.last),
  .status_i       (res_o.status)
);

// ===== sim/tb_servo_status_packet_deframer.sv =====
// Self-checking testbench for servo_status_packet_deframer: frames, bad starts,
// bad lengths and checksum failures under random idling, stalls and limit changes.
// Depends on ssd_pkg, the channel interfaces and the deframer RTL.
module tb_servo_status_packet_deframer;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [ssd_pkg::MAX_BYTES_W-1:0] cfg_wdata_i;

  ssd_byte_if   rx_if();
  ssd_result_if res_if();

  servo_status_packet_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the parser state, updated on every accepted byte request.
  ssd_pkg::phase_e                 parse_ph;
  logic [7:0]                      frame_id;
  logic [7:0]                      frame_len;
  logic [7:0]                      body_left;
  logic [7:0]                      body_sum;
  logic [7:0]                      body_cnt;
  logic [ssd_pkg::MAX_BYTES_W-1:0] max_bytes;

  ssd_pkg::result_t pending_results[$];
  int               n_errors;
  int               n_bytes_sent;
  bit               idle_en;
  int               hold_cycles;

  function automatic void parse_byte(input logic [7:0] b);
    ssd_pkg::result_t r;
    r = '0;
    case (parse_ph)
      ssd_pkg::PH_START2: begin
        if (b != ssd_pkg::START_BYTE) begin
          parse_ph = ssd_pkg::PH_START1;
          r.last = 1'b1;
          r.status = ssd_pkg::ST_BAD_START;
          pending_results.push_back(r);
        end else begin
          parse_ph = ssd_pkg::PH_ID;
        end
      end
      ssd_pkg::PH_ID: begin
        frame_id = b;
        parse_ph = ssd_pkg::PH_LEN;
      end
      ssd_pkg::PH_LEN: begin
        frame_len = b;
        if (b == 8'd0 || 32'(b) + ssd_pkg::FRAME_OVERHEAD > 32'(max_bytes)) begin
          parse_ph = ssd_pkg::PH_START1;
          r.device_id = frame_id;
          r.frame_length = frame_len;
          r.last = 1'b1;
          r.status = ssd_pkg::ST_BAD_LEN;
          pending_results.push_back(r);
        end else begin
          body_sum = frame_id + b;
          body_cnt = 8'd0;
          body_left = b - 8'd1;
          parse_ph = (body_left == 8'd0) ? ssd_pkg::PH_CSUM : ssd_pkg::PH_BODY;
        end
      end
      ssd_pkg::PH_BODY: begin
        r.body_byte = b;
        r.body_index = body_cnt;
        r.device_id = frame_id;
        r.frame_length = frame_len;
        r.status = ssd_pkg::ST_OK;
        pending_results.push_back(r);
        body_sum = body_sum + b;
        body_cnt = body_cnt + 8'd1;
        body_left = body_left - 8'd1;
        if (body_left == 8'd0) parse_ph = ssd_pkg::PH_CSUM;
      end
      ssd_pkg::PH_CSUM: begin
        parse_ph = ssd_pkg::PH_START1;
        r.device_id = frame_id;
        r.frame_length = frame_len;
        r.last = 1'b1;
        r.status = (b == ~body_sum) ? ssd_pkg::ST_OK : ssd_pkg::ST_BAD_CSUM;
        pending_results.push_back(r);
      end
      default: begin
        if (b != ssd_pkg::START_BYTE) begin
          parse_ph = ssd_pkg::PH_START1;
          r.last = 1'b1;
          r.status = ssd_pkg::ST_BAD_START;
          pending_results.push_back(r);
        end else begin
          parse_ph = ssd_pkg::PH_START2;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_result();
    ssd_pkg::result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, body_byte", res_if.body_byte, 0);
    end else begin
      want = pending_results.pop_front();
      if (res_if.body_byte !== want.body_byte)
        report_mismatch("body_byte", res_if.body_byte, want.body_byte);
      if (res_if.body_index !== want.body_index)
        report_mismatch("body_index", res_if.body_index, want.body_index);
      if (res_if.device_id !== want.device_id)
        report_mismatch("device_id", res_if.device_id, want.device_id);
      if (res_if.frame_length !== want.frame_length)
        report_mismatch("frame_length", res_if.frame_length, want.frame_length);
      if (res_if.last !== want.last)
        report_mismatch("last", res_if.last, want.last);
      if (res_if.status !== want.status)
        report_mismatch("status", res_if.status, want.status);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rx_if.valid && rx_if.ready) parse_byte(rx_if.rx_byte);
    if (rst_ni && res_if.valid && res_if.ready) check_result();
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always begin
    @(posedge clk_i);
    if (hold_cycles > 0) begin
      res_if.ready <= 1'b0;
      repeat (hold_cycles) @(posedge clk_i);
      hold_cycles = 0;
    end else begin
      res_if.ready <= !(idle_en && $urandom_range(99) < 28);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(99) < 28) begin
      rx_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 28);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    n_bytes_sent++;
  endtask

  // A negative fill draws every body byte at random.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input int fill,
                            input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = id + len;
    send_byte(ssd_pkg::START_BYTE);
    send_byte(ssd_pkg::START_BYTE);
    send_byte(id);
    send_byte(len);
    if (len == 8'd0 || 32'(len) + ssd_pkg::FRAME_OVERHEAD > 32'(max_bytes)) return;
    for (int i = 1; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum = sum + b;
      send_byte(b);
    end
    b = ~sum;
    if (bad_sum) b = b ^ (8'd1 << $urandom_range(7));
    send_byte(b);
  endtask

  // Waits until every expected result has arrived and the pipeline is empty.
  // The first edge lets the checker record the last accepted byte request.
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_bytes(input logic [ssd_pkg::MAX_BYTES_W-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_bytes = v;
  endtask

  task automatic test_special_cases();
    send_frame(8'h00, 8'd2, 8'h00, 1'b0);
    send_frame(8'hFF, 8'd4, 8'hFF, 1'b0);
    send_frame(8'h7F, 8'd1, 0, 1'b0);
    send_frame(8'h01, 8'd3, 8'h80, 1'b1);
    send_byte(8'h00);
    send_byte(ssd_pkg::START_BYTE);
    send_byte(8'h7E);
    send_frame(8'h33, 8'd0, 0, 1'b0);
    send_frame(8'h55, 8'd3, -1, 1'b0);
  endtask

  task automatic test_length_limits();
    write_max_bytes(9'd5);
    send_frame(8'h10, 8'd1, 0, 1'b0);
    send_frame(8'h11, 8'd2, 0, 1'b0);
    write_max_bytes(9'd4);
    send_frame(8'h12, 8'd1, 0, 1'b0);
    write_max_bytes(9'd0);
    send_frame(8'h13, 8'd1, 0, 1'b0);
    send_frame(8'h14, 8'd255, 0, 1'b0);
    write_max_bytes(9'd100);
    send_frame(8'h15, 8'd96, -1, 1'b0);
    send_frame(8'h16, 8'd97, -1, 1'b0);
    write_max_bytes(9'd258);
    send_frame(8'h17, 8'd255, -1, 1'b0);
    write_max_bytes(9'd259);
    send_frame(8'h18, 8'd255, -1, 1'b0);
    write_max_bytes(9'd511);
    send_frame(8'h19, 8'd255, 8'hFF, 1'b1);
  endtask

  task automatic random_segment(input int n_target);
    int         start_cnt;
    int         r;
    int         lo;
    logic [7:0] len;
    start_cnt = n_bytes_sent;
    while (n_bytes_sent - start_cnt < n_target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = ($urandom_range(99) < 85) ? 8'($urandom_range(1, 12)) : 8'($urandom_range(1, 255));
        send_frame(8'($urandom), len, -1, $urandom_range(99) < 10);
      end else if (r < 80) begin
        lo = int'(max_bytes) - 3;
        if (lo > 255 || $urandom_range(1) == 0) len = 8'd0;
        else len = 8'($urandom_range(lo < 1 ? 1 : lo, 255));
        send_frame(8'($urandom), len, 0, 1'b0);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        // Frame broken off partway through its header.
        send_byte(ssd_pkg::START_BYTE);
        if ($urandom_range(1) == 1) send_byte(ssd_pkg::START_BYTE);
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    write_max_bytes(9'd259);
    random_segment(100);
    idle_en = 1'b0;
    random_segment(100);
    idle_en = 1'b1;
    write_max_bytes(9'($urandom_range(5, 60)));
    random_segment(100);
    write_max_bytes(9'($urandom_range(200, 511)));
    random_segment(100);
  endtask

  task automatic test_backpressure();
    write_max_bytes(9'd259);
    hold_cycles = 60;
    send_frame(8'hA5, 8'd40, -1, 1'b0);
    send_frame(8'h5A, 8'd6, -1, 1'b1);
  endtask

  task automatic test_sender_pause();
    send_frame(8'h3C, 8'd5, -1, 1'b0);
    wait_idle();
    send_frame(8'hC3, 8'd5, -1, 1'b0);
    send_byte(8'h01);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready = 1'b0;
    parse_ph = ssd_pkg::PH_START1;
    frame_id = 8'h00;
    frame_len = 8'h00;
    body_left = 8'h00;
    body_sum = 8'h00;
    body_cnt = 8'h00;
    max_bytes = ssd_pkg::MAX_BYTES_RESET;
    n_errors = 0;
    n_bytes_sent = 0;
    idle_en = 1'b1;
    hold_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_length_limits();
    test_backpressure();
    test_sender_pause();
    test_random_traffic();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ssd_pkg.sv
hdl/ssd_byte_if.sv
hdl/ssd_in_stage.sv
hdl/ssd_parser.sv
hdl/ssd_out_stage.sv
hdl/servo_status_packet_deframer.sv
hdl/ssd_checker.sv
sim/tb_servo_status_packet_deframer.sv
